// ===== hdl/nlej_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Nested-loop equi-join package
// Shared types for item payloads and the controller/datapath link.
// ----------------------------------------------------------------------------
package nlej_pkg;

  localparam int unsigned IDX_W   = 6;
  localparam int unsigned COUNT_W = 7;
  localparam int unsigned SEQ_W   = 16;

  typedef enum logic [1:0] {
    MODE_LOAD  = 2'd0,
    MODE_PROBE = 2'd1,
    MODE_CLEAR = 2'd2
  } mode_t;

  typedef struct packed {
    mode_t        mode;
    logic [63:0]  key_w0;
    logic [63:0]  key_w1;
    logic [63:0]  key_w2;
    logic [47:0]  key_w3;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] build_index;
    logic [SEQ_W-1:0] probe_index;
    logic             last_match;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic             load;
    logic             clear;
    logic             probe;
    logic             rd_en;
    logic             flush;
    logic [IDX_W-1:0] rd_addr;
  } dp_cmd_t;

  typedef struct packed {
    logic               go;
    logic [COUNT_W-1:0] count;
  } dp_status_t;

endpackage
`default_nettype wire

// ===== hdl/nested_loop_equi_join_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Nested-loop equi-join top level
// Load, probe and clear items; emits one item per matching stored key.
// ----------------------------------------------------------------------------
// Load, clear and unused items and probes of an empty table are taken in idle.
// A probe against stored keys holds the input for a scan of one table read
// per cycle through the registered read port, then a drain and a flush state;
// a stalled output pauses the scan. Matches leave at most one per cycle, each
// held back until the next match or the flush sets its flag.
// Synchronous active-low reset empties the table count and probe counter.
module nested_loop_equi_join_top #(
  parameter int MAX_BUILD  = 64,
  parameter int KEY_BYTES  = 30,
  parameter int PROBE_BITS = 16
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  nlej_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  wire                 out_ready,
  output nlej_pkg::out_item_t out_data
);

  nlej_pkg::dp_cmd_t    cmd;
  nlej_pkg::dp_status_t status;

  nlej_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_mode  (in_data.mode),
    .status   (status),
    .cmd      (cmd)
  );

  nlej_dp #(
    .MAX_BUILD  (MAX_BUILD),
    .KEY_BYTES  (KEY_BYTES),
    .PROBE_BITS (PROBE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// ===== hdl/nlej_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Nested-loop equi-join controller
// Decodes items and sequences the table scan for probes of a non-empty table.
// ----------------------------------------------------------------------------
module nlej_ctrl (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  nlej_pkg::mode_t      in_mode,
  input  nlej_pkg::dp_status_t status,
  output nlej_pkg::dp_cmd_t    cmd
);

  nlej_pkg::state_t state_r, state_nxt;
  logic [nlej_pkg::IDX_W-1:0] scan_idx_r, scan_idx_nxt;
  logic last_addr;

  assign last_addr = ({1'b0, scan_idx_r} + nlej_pkg::COUNT_W'(1)) == status.count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= nlej_pkg::ST_IDLE;
      scan_idx_r <= '0;
    end else begin
      state_r    <= state_nxt;
      scan_idx_r <= scan_idx_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      nlej_pkg::ST_IDLE: begin
        if (in_valid && in_mode == nlej_pkg::MODE_PROBE && status.count != '0) begin
          state_nxt = nlej_pkg::ST_SCAN;
        end
      end
      nlej_pkg::ST_SCAN: begin
        if (status.go && last_addr) begin
          state_nxt = nlej_pkg::ST_DRAIN;
        end
      end
      nlej_pkg::ST_DRAIN: begin
        if (status.go) begin
          state_nxt = nlej_pkg::ST_FLUSH;
        end
      end
      nlej_pkg::ST_FLUSH: begin
        if (status.go) begin
          state_nxt = nlej_pkg::ST_IDLE;
        end
      end
      default: state_nxt = nlej_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    scan_idx_nxt = scan_idx_r;
    if (state_r == nlej_pkg::ST_IDLE) begin
      scan_idx_nxt = '0;
    end else if (state_r == nlej_pkg::ST_SCAN && status.go) begin
      scan_idx_nxt = scan_idx_r + nlej_pkg::IDX_W'(1);
    end
  end

  always_comb begin
    in_ready    = 1'b0;
    cmd         = '0;
    cmd.rd_addr = scan_idx_r;
    case (state_r)
      nlej_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (in_mode)
            nlej_pkg::MODE_LOAD:  cmd.load  = 1'b1;
            nlej_pkg::MODE_PROBE: cmd.probe = 1'b1;
            nlej_pkg::MODE_CLEAR: cmd.clear = 1'b1;
            default: ;
          endcase
        end
      end
      nlej_pkg::ST_SCAN:  cmd.rd_en = status.go;
      nlej_pkg::ST_FLUSH: cmd.flush = status.go;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ===== hdl/nlej_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Nested-loop equi-join datapath
// Key table, probe key and counters, compare stage, pending match and
// output register.
// ----------------------------------------------------------------------------
module nlej_dp #(
  parameter int MAX_BUILD  = 64,
  parameter int KEY_BYTES  = 30,
  parameter int PROBE_BITS = 16
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  nlej_pkg::in_item_t   in_data,
  input  nlej_pkg::dp_cmd_t    cmd,
  output nlej_pkg::dp_status_t status,
  output logic                 out_valid,
  input  wire                  out_ready,
  output nlej_pkg::out_item_t  out_data
);

  localparam int AW = (MAX_BUILD > 1) ? $clog2(MAX_BUILD) : 1;
  localparam logic [nlej_pkg::COUNT_W-1:0] MAX_CNT = nlej_pkg::COUNT_W'(MAX_BUILD);
  localparam logic [PROBE_BITS-1:0] PROBE_MAX = '1;

  function automatic logic [239:0] normalize(input logic [239:0] raw);
    logic [239:0] k;
    logic         ended;
    k     = '0;
    ended = 1'b0;
    for (int b = 0; b < 30; b++) begin
      if (b >= KEY_BYTES || raw[8*b +: 8] == 8'h00) ended = 1'b1;
      if (!ended) k[8*b +: 8] = raw[8*b +: 8];
    end
    return k;
  endfunction

  logic [239:0] mem [MAX_BUILD];
  logic [239:0] key_in;
  logic [239:0] key_r;
  logic [239:0] rd_data_r;
  logic [nlej_pkg::COUNT_W-1:0] count_r, count_nxt;
  logic [PROBE_BITS-1:0] probe_cnt_r, probe_cnt_nxt;
  logic [PROBE_BITS+nlej_pkg::SEQ_W-1:0] probe_wide;
  logic [nlej_pkg::SEQ_W-1:0] seq_r;
  logic cmp_vld_r;
  logic [nlej_pkg::IDX_W-1:0] cmp_idx_r;
  logic pend_valid_r, pend_valid_nxt;
  logic [nlej_pkg::IDX_W-1:0] pend_idx_r, pend_idx_nxt;
  logic out_valid_r, out_valid_nxt;
  nlej_pkg::out_item_t out_data_r, out_data_nxt;
  logic go, match, wr_en;

  assign key_in     = normalize({in_data.key_w3, in_data.key_w2, in_data.key_w1, in_data.key_w0});
  assign go         = !out_valid_r || out_ready;
  assign match      = rd_data_r == key_r;
  assign wr_en      = cmd.load && (count_r < MAX_CNT);
  assign probe_wide = {{nlej_pkg::SEQ_W{1'b0}}, probe_cnt_r};

  assign status.go    = go;
  assign status.count = count_r;
  assign out_valid    = out_valid_r;
  assign out_data     = out_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count_r[AW-1:0]] <= key_in;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[cmd.rd_addr[AW-1:0]];
    end
  end

  always_comb begin
    count_nxt     = count_r;
    probe_cnt_nxt = probe_cnt_r;
    if (cmd.clear) begin
      count_nxt     = '0;
      probe_cnt_nxt = '0;
    end else begin
      if (wr_en) count_nxt = count_r + nlej_pkg::COUNT_W'(1);
      if (cmd.probe && probe_cnt_r != PROBE_MAX) probe_cnt_nxt = probe_cnt_r + PROBE_BITS'(1);
    end
  end

  always_comb begin
    out_valid_nxt  = out_valid_r && !out_ready;
    out_data_nxt   = out_data_r;
    pend_valid_nxt = pend_valid_r;
    pend_idx_nxt   = pend_idx_r;
    if (go && cmp_vld_r && match) begin
      if (pend_valid_r) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = '{build_index: pend_idx_r, probe_index: seq_r, last_match: 1'b0};
      end
      pend_valid_nxt = 1'b1;
      pend_idx_nxt   = cmp_idx_r;
    end
    if (go && cmd.flush && pend_valid_r) begin
      out_valid_nxt  = 1'b1;
      out_data_nxt   = '{build_index: pend_idx_r, probe_index: seq_r, last_match: 1'b1};
      pend_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      probe_cnt_r  <= '0;
      cmp_vld_r    <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      count_r      <= count_nxt;
      probe_cnt_r  <= probe_cnt_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      if (go) cmp_vld_r <= cmd.rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.probe) begin
      key_r <= key_in;
      seq_r <= probe_wide[nlej_pkg::SEQ_W-1:0];
    end
    if (go) cmp_idx_r <= cmd.rd_addr;
    pend_idx_r <= pend_idx_nxt;
    out_data_r <= out_data_nxt;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= MAX_CNT)
    else $error("table count beyond capacity");

  a_rd_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_en |-> ({1'b0, cmd.rd_addr} < count_r))
    else $error("scan read beyond stored keys");

  a_flush_after_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.flush |-> !cmp_vld_r)
    else $error("flush while a compare is in flight");

  a_pend_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (go && cmp_vld_r && match) |=> pend_valid_r)
    else $error("match lost from pending register");

endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nested-loop equi-join testbench
// Directed rows, a short repeated-probe stream and random load/probe
// bursts, each accepted item run through an in-bench join model and every
// emitted match checked field by field, with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb;

  localparam logic [1:0]                 MODE_UNUSED    = 2'd3;
  localparam int unsigned                TABLE_DEPTH    = 64;
  localparam int unsigned                KEY_LEN        = 30;
  localparam logic [nlej_pkg::SEQ_W-1:0] SEQ_TOP        = '1;
  localparam int unsigned                RANDOM_ITEMS   = 195;
  localparam int unsigned                REPEAT_PROBES  = 4;
  localparam int unsigned                WATCHDOG_LIMIT = 5000;
  localparam int unsigned                DRAIN_CYCLES   = 80;
  localparam int unsigned                MAX_PRINTS     = 40;

  localparam logic [239:0] KEY_EMPTY     = '0;
  localparam logic [239:0] KEY_ONES      = '1;
  localparam logic [239:0] KEY_AB        = {{28{8'h00}}, 8'h62, 8'h61};
  localparam logic [239:0] KEY_AB_JUNK   = {{27{8'h5A}}, 8'h00, 8'h62, 8'h61};
  localparam logic [239:0] KEY_AB_JUNK2  = {{27{8'hC3}}, 8'h00, 8'h62, 8'h61};
  localparam logic [239:0] KEY_ABC       = {{27{8'h00}}, 8'h63, 8'h62, 8'h61};
  localparam logic [239:0] KEY_ZERO_JUNK = {{29{8'hA5}}, 8'h00};
  localparam logic [239:0] KEY_29A       = {8'h00, {29{8'h41}}};
  localparam logic [239:0] KEY_30A       = {30{8'h41}};

  typedef struct {
    nlej_pkg::in_item_t  item;
    int                  n_typed;
    nlej_pkg::out_item_t r0;
    nlej_pkg::out_item_t r1;
  } step_row_t;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  nlej_pkg::in_item_t  in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  nlej_pkg::out_item_t out_data;

  // join model state
  logic [239:0]               join_keys [TABLE_DEPTH];
  int unsigned                key_count = 0;
  logic [nlej_pkg::SEQ_W-1:0] probe_seq = '0;
  nlej_pkg::out_item_t        pending_matches[$];

  step_row_t    directed_rows[$];
  logic [239:0] pool_key [4];
  int unsigned  pool_len [4];

  int unsigned mismatches    = 0;
  int unsigned results_seen  = 0;
  int unsigned random_items  = 0;
  int unsigned widest_answer = 0;
  int unsigned idle_cycles   = 0;
  int unsigned rx_hold       = 0;
  bit          rx_smooth     = 1'b0;

  nested_loop_equi_join_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic nlej_pkg::out_item_t hit(int unsigned idx, int unsigned seq, bit last);
    nlej_pkg::out_item_t r;
    r.build_index = nlej_pkg::IDX_W'(idx);
    r.probe_index = nlej_pkg::SEQ_W'(seq);
    r.last_match  = last;
    return r;
  endfunction

  function automatic nlej_pkg::in_item_t mk_item(logic [1:0] m, logic [239:0] k);
    nlej_pkg::in_item_t it;
    it.mode   = nlej_pkg::mode_t'(m);
    it.key_w0 = k[63:0];
    it.key_w1 = k[127:64];
    it.key_w2 = k[191:128];
    it.key_w3 = k[239:192];
    return it;
  endfunction

  function automatic void add_row(logic [1:0] m, logic [239:0] k, int n = -1,
                                  nlej_pkg::out_item_t r0 = '0,
                                  nlej_pkg::out_item_t r1 = '0);
    step_row_t row;
    row.item    = mk_item(m, k);
    row.n_typed = n;
    row.r0      = r0;
    row.r1      = r1;
    directed_rows.push_back(row);
  endfunction

  // bytes after the terminator count for nothing, as with C strings
  function automatic logic [239:0] c_string_key(nlej_pkg::in_item_t it);
    logic [239:0] raw;
    logic [239:0] k;
    bit           ended;
    raw   = {it.key_w3, it.key_w2, it.key_w1, it.key_w0};
    k     = '0;
    ended = 1'b0;
    for (int b = 0; b < KEY_LEN; b++) begin
      if (raw[8*b +: 8] == 8'h00) ended = 1'b1;
      if (!ended) k[8*b +: 8] = raw[8*b +: 8];
    end
    return k;
  endfunction

  function automatic void forecast_join(input nlej_pkg::in_item_t it,
                                        output nlej_pkg::out_item_t found[$]);
    logic [239:0]               k;
    logic [nlej_pkg::SEQ_W-1:0] seq;
    found = {};
    k     = c_string_key(it);
    case (it.mode)
      nlej_pkg::MODE_CLEAR: begin
        key_count = 0;
        probe_seq = '0;
      end
      nlej_pkg::MODE_LOAD: begin
        if (key_count < TABLE_DEPTH) begin
          join_keys[key_count] = k;
          key_count++;
        end
      end
      nlej_pkg::MODE_PROBE: begin
        seq = probe_seq;
        if (probe_seq != SEQ_TOP) probe_seq++;
        for (int j = 0; j < key_count; j++)
          if (join_keys[j] == k) found.push_back(hit(j, 32'(seq), 1'b0));
        if (found.size() > 0) found[found.size()-1].last_match = 1'b1;
      end
      default: ;
    endcase
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [239:0] raw_key();
    logic [255:0] t;
    t = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    return t[239:0];
  endfunction

  function automatic logic [239:0] pool_pick(int unsigned p);
    logic [239:0] k;
    k = pool_key[p];
    if (pool_len[p] + 1 < KEY_LEN && $urandom_range(0, 1) == 1)
      for (int b = pool_len[p] + 1; b < KEY_LEN; b++) k[8*b +: 8] = 8'($urandom);
    return k;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (mismatches < MAX_PRINTS)
      $display("%0t %s: got %0h expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic push_item(input nlej_pkg::in_item_t it, input int n_typed,
                           input nlej_pkg::out_item_t t0, input nlej_pkg::out_item_t t1);
    nlej_pkg::out_item_t found[$];
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    forecast_join(it, found);
    if (found.size() > widest_answer) widest_answer = found.size();
    if (n_typed < 0) begin
      foreach (found[i]) pending_matches.push_back(found[i]);
    end else begin
      if (n_typed > 0) pending_matches.push_back(t0);
      if (n_typed > 1) pending_matches.push_back(t1);
    end
  endtask

  task automatic idle_gap(int unsigned n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain_matches();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_matches.size() != 0) @(posedge clk);
  endtask

  task automatic send_random(input nlej_pkg::in_item_t it, input bit smooth);
    push_item(it, -1, '0, '0);
    if (it.mode != MODE_UNUSED) random_items++;
    idle_gap(smooth ? 0 : pick_gap());
  endtask

  always @(posedge clk) begin
    if (rx_hold != 0) begin
      out_ready <= 1'b0;
      rx_hold   <= rx_hold - 1;
    end else begin
      out_ready <= 1'b1;
      if (!rx_smooth && $urandom_range(0, 3) == 0) rx_hold <= pick_gap();
    end
  end

  always @(posedge clk) begin
    nlej_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_matches.size() == 0) begin
        report_mismatch("result with nothing expected", 32'(out_data), '1);
      end else begin
        want = pending_matches.pop_front();
        if (out_data.build_index !== want.build_index)
          report_mismatch("build_index", 32'(out_data.build_index),
                          32'(want.build_index));
        if (out_data.probe_index !== want.probe_index)
          report_mismatch("probe_index", 32'(out_data.probe_index),
                          32'(want.probe_index));
        if (out_data.last_match !== want.last_match)
          report_mismatch("last_match", 32'(out_data.last_match),
                          32'(want.last_match));
      end
    end
    if (rst_n && ((in_valid && in_ready) || (out_valid && out_ready))) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("nested_loop_equi_join_top: mismatch");
    $finish;
  end

  initial begin
    bit          smooth;
    bit          fresh;
    bit          wide;
    bit          fill;
    int unsigned n_loads;
    int unsigned n_probes;

    add_row(nlej_pkg::MODE_PROBE, KEY_AB, 0);
    add_row(MODE_UNUSED,          KEY_ONES, 0);
    add_row(nlej_pkg::MODE_LOAD,  KEY_EMPTY, 0);
    add_row(nlej_pkg::MODE_LOAD,  KEY_ONES, 0);
    add_row(nlej_pkg::MODE_LOAD,  KEY_AB_JUNK, 0);
    add_row(nlej_pkg::MODE_LOAD,  KEY_AB, 0);
    add_row(nlej_pkg::MODE_PROBE, KEY_EMPTY, 1, hit(0, 1, 1));
    add_row(nlej_pkg::MODE_PROBE, KEY_ONES, 1, hit(1, 2, 1));
    add_row(nlej_pkg::MODE_PROBE, KEY_AB_JUNK2, 2, hit(2, 3, 0), hit(3, 3, 1));
    add_row(nlej_pkg::MODE_PROBE, KEY_ABC);
    add_row(nlej_pkg::MODE_PROBE, KEY_ZERO_JUNK, 1, hit(0, 5, 1));
    add_row(MODE_UNUSED,          KEY_AB, 0);
    add_row(nlej_pkg::MODE_LOAD,  KEY_29A);
    add_row(nlej_pkg::MODE_PROBE, KEY_30A);
    add_row(nlej_pkg::MODE_PROBE, KEY_29A, 1, hit(4, 7, 1));
    add_row(nlej_pkg::MODE_LOAD,  KEY_30A);
    add_row(nlej_pkg::MODE_PROBE, KEY_30A, 1, hit(5, 8, 1));
    add_row(nlej_pkg::MODE_CLEAR, KEY_ONES, 0);
    add_row(nlej_pkg::MODE_PROBE, KEY_AB, 0);
    add_row(nlej_pkg::MODE_LOAD,  KEY_AB_JUNK2);
    add_row(nlej_pkg::MODE_PROBE, KEY_AB, 1, hit(0, 1, 1));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      push_item(directed_rows[i].item, directed_rows[i].n_typed,
                directed_rows[i].r0, directed_rows[i].r1);
      idle_gap(pick_gap());
    end

    // one more key, then the same key probed with junk after its terminator
    push_item(mk_item(nlej_pkg::MODE_LOAD, KEY_AB), -1, '0, '0);
    for (int s = 0; s < REPEAT_PROBES; s++) begin
      push_item(mk_item(nlej_pkg::MODE_PROBE, KEY_AB_JUNK), -1, '0, '0);
      idle_gap(pick_gap());
    end

    fresh = 1'b1;
    while (random_items < RANDOM_ITEMS) begin
      smooth = ($urandom_range(0, 4) == 0);
      rx_smooth <= smooth;
      for (int p = 0; p < 4; p++) begin
        wide        = ($urandom_range(0, 5) == 0);
        pool_len[p] = ($urandom_range(0, 7) == 0) ? $urandom_range(4, KEY_LEN)
                                                  : $urandom_range(0, 3);
        pool_key[p] = '0;
        for (int b = 0; b < pool_len[p]; b++)
          pool_key[p][8*b +: 8] = wide ? 8'($urandom_range(1, 255))
                                       : 8'($urandom_range(8'h61, 8'h62));
      end
      fill = fresh || ($urandom_range(0, 7) == 0);
      if (fill || $urandom_range(0, 1) == 1)
        send_random(mk_item(nlej_pkg::MODE_CLEAR, raw_key()), smooth);
      n_loads = fill ? TABLE_DEPTH + 1 + $urandom_range(0, 2) : $urandom_range(0, 10);
      for (int l = 0; l < n_loads && random_items < RANDOM_ITEMS; l++) begin
        if (fresh)
          send_random(mk_item(nlej_pkg::MODE_LOAD, pool_pick(0)), smooth);
        else if ($urandom_range(0, 7) == 0)
          send_random(mk_item(nlej_pkg::MODE_LOAD, raw_key()), smooth);
        else
          send_random(mk_item(nlej_pkg::MODE_LOAD, pool_pick($urandom_range(0, 3))),
                      smooth);
      end
      n_probes = $urandom_range(1, 8);
      for (int q = 0; q < n_probes; q++) begin
        if ($urandom_range(0, 11) == 0)
          send_random(mk_item(MODE_UNUSED, raw_key()), smooth);
        if (fresh && q == 0)
          send_random(mk_item(nlej_pkg::MODE_PROBE, pool_pick(0)), smooth);
        else if ($urandom_range(0, 9) < 3)
          send_random(mk_item(nlej_pkg::MODE_PROBE, raw_key()), smooth);
        else
          send_random(mk_item(nlej_pkg::MODE_PROBE, pool_pick($urandom_range(0, 3))),
                      smooth);
      end
      if (fresh || $urandom_range(0, 3) == 0) drain_matches();
      fresh = 1'b0;
    end

    drain_matches();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("stimulus: %0d directed items, %0d random load/probe/clear items",
             directed_rows.size() + REPEAT_PROBES + 1, random_items);
    $display("results: %0d matches checked, widest probe answer %0d, %0d mismatches",
             results_seen, widest_answer, mismatches);
    if (mismatches == 0 && pending_matches.size() == 0) begin
      $display("nested_loop_equi_join_top: match");
    end else begin
      $display("nested_loop_equi_join_top: mismatch");
    end
    $finish;
  end

endmodule
